// ===== src/fird_pkg.sv =====
// Shared constants, register codes and the MAC control struct for the FIR decimator.
// No dependencies; every other file of the block but fird_ram imports this package.
`default_nettype none

package fird_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 18;
	localparam int FRAC_SHIFT   = COEF_WIDTH - 2;
	localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int MAX_FACTOR   = 16;
	localparam int DEF_MAX_TAPS = 64;

	localparam int FACTOR_W = 5;
	localparam int TAPS_W   = 7;
	localparam int PHASE_W  = 4;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 18;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	localparam logic REG_FACTOR = 1'b0;
	localparam logic REG_TAPS   = 1'b1;

	localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
	localparam logic [TAPS_W-1:0]   RST_TAPS   = 7'd64;

	typedef struct packed {
		logic vld;
		logic clr;
		logic last;
		logic nul;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ===== src/fird_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Uses no package; holds the delay line and the coefficient store.
`default_nettype none

module fird_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/fird_cfg.sv =====
// APB-style register file: decimation factor and number of taps in use.
// Depends on fird_pkg for widths, register codes and reset values.
`default_nettype none

module fird_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fird_pkg::PADDR_W-1:0]     paddr,
	input  logic [fird_pkg::PDATA_W-1:0]     pwdata,
	output logic [fird_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	output logic [fird_pkg::FACTOR_W-1:0]    factor,
	output logic [fird_pkg::TAPS_W-1:0]      taps
);
	import fird_pkg::*;

	logic                wr;
	logic                reg_sel;
	logic [FACTOR_W-1:0] factor_q;
	logic [TAPS_W-1:0]   taps_q;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= RST_FACTOR;
			taps_q   <= RST_TAPS;
		end else if (wr) begin
			unique case (reg_sel)
				REG_FACTOR: factor_q <= pwdata[FACTOR_W-1:0];
				REG_TAPS:   taps_q   <= pwdata[TAPS_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_FACTOR: prdata = PDATA_W'(factor_q);
			REG_TAPS:   prdata = PDATA_W'(taps_q);
			default:    prdata = '0;
		endcase
	end

	assign factor = factor_q;
	assign taps   = taps_q;

endmodule

`default_nettype wire

// ===== src/fird_mac.sv =====
// Shared multiply-accumulate pipeline with round-half-up, shift and saturation.
// Depends on fird_pkg for widths and the mac_ctl_t control struct.
`default_nettype none

module fird_mac #(
	parameter int ACC_W = 41
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fird_pkg::mac_ctl_t                     ctl,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] smp,
	input  logic signed [fird_pkg::COEF_WIDTH-1:0]   coef,
	output logic                                   done,
	output logic [fird_pkg::SAMPLE_WIDTH-1:0]      result
);
	import fird_pkg::*;

	localparam int SH_W = ACC_W + 1 - FRAC_SHIFT;
	localparam logic signed [ACC_W:0]    HALF   = (ACC_W + 1)'(2 ** (FRAC_SHIFT - 1));
	localparam logic signed [SH_W-1:0]   OUT_HI = SH_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
	localparam logic signed [SH_W-1:0]   OUT_LO = SH_W'(-(2 ** (SAMPLE_WIDTH - 1)));

	mac_ctl_t                 ctl_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     last_s4;
	logic                     done_q;
	logic [SAMPLE_WIDTH-1:0]  res_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W:0]    rnd;
	logic signed [SH_W-1:0]   shf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3  <= '0;
			last_s4 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			ctl_s3  <= ctl;
			last_s4 <= ctl_s3.vld && ctl_s3.last;
			done_q  <= last_s4;
		end
	end

	// a disabled or unwritten tap contributes nothing
	always_ff @(posedge clk) begin
		if (ctl.nul) begin
			prod_s3 <= '0;
		end else begin
			prod_s3 <= smp * coef;
		end
	end

	assign prod_ext = {{(ACC_W - PROD_W){prod_s3[PROD_W-1]}}, prod_s3};

	always_ff @(posedge clk) begin
		if (ctl_s3.vld) begin
			if (ctl_s3.clr) begin
				acc_q <= prod_ext;
			end else begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	assign rnd = $signed({acc_q[ACC_W-1], acc_q}) + HALF;
	assign shf = $signed(rnd[ACC_W:FRAC_SHIFT]);

	always_ff @(posedge clk) begin
		if (last_s4) begin
			priority if (shf > OUT_HI) begin
				res_q <= OUT_HI[SAMPLE_WIDTH-1:0];
			end else if (shf < OUT_LO) begin
				res_q <= OUT_LO[SAMPLE_WIDTH-1:0];
			end else begin
				res_q <= shf[SAMPLE_WIDTH-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== src/fir_decimator.sv =====
// Top level of the FIR decimator: stream ports, sequencer, delay-line and coefficient RAMs.
// Depends on fird_pkg, fird_ram, fird_cfg and fird_mac.
`default_nettype none

// FIR decimator for Q1.15 audio with Q2.16 coefficients. Each request on the input stream
// is either a coefficient write (tuser high) or a sample (tuser low). Coefficient writes
// and samples that do not complete a decimation period leave the block idle. A sample that
// completes a period starts one pass over the taps in use: a single shared multiplier
// walks the delay-line RAM and the coefficient RAM one tap per cycle over
// max(min(taps_in_use, MAX_TAPS), 1) taps, after which the rounded, saturated result is
// placed in the output register once that register is free. The input takes the next
// request as soon as the result is in that register, even if the output side is stalled.
// Both RAMs read as zero until an entry is written; no clearing pass.
module fir_decimator #(
	parameter int MAX_TAPS = fird_pkg::DEF_MAX_TAPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,  // [5:0] coef_index, [23:6] value
	input  logic                          s_tuser,  // [0] cmd
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // [15:0] sample_out
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fird_pkg::PADDR_W-1:0]  paddr,
	input  logic [fird_pkg::PDATA_W-1:0]  pwdata,
	output logic [fird_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import fird_pkg::*;

	localparam int AW    = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = PROD_W + CNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [FACTOR_W-1:0] factor;
	logic [TAPS_W-1:0]   taps;

	logic                in_cmd;
	logic [INDEX_W-1:0]  in_idx;
	logic [VALUE_W-1:0]  in_val;
	logic                req;
	logic                smp_wr;
	logic                coef_wr;
	logic                due;

	logic [1:0]          state_q;
	logic [AW-1:0]       wptr_q;
	logic [AW-1:0]       wptr_nxt;
	logic [AW-1:0]       rptr_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [PHASE_W-1:0]  phase_lim;
	logic [FACTOR_W-1:0] fac_eff;
	logic [CNT_W-1:0]    taps_eff;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    n_q;
	logic                nul_q;
	logic [MAX_TAPS-1:0] dv_q;
	logic [MAX_TAPS-1:0] cv_q;
	logic                dv_s2;
	logic                cv_s2;

	mac_ctl_t            issue;
	mac_ctl_t            ctl_s2;
	mac_ctl_t            mac_ctl;

	logic [SAMPLE_WIDTH-1:0] smp_rd;
	logic [COEF_WIDTH-1:0]   coef_rd;
	logic                    mac_done;
	logic [SAMPLE_WIDTH-1:0] mac_result;

	logic                    m_tvalid_q;
	logic [SAMPLE_WIDTH-1:0] out_q;
	logic                    load_out;

	fird_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.factor  (factor),
		.taps    (taps)
	);

	assign in_cmd = s_tuser;
	assign in_idx = s_tdata[INDEX_W-1:0];
	assign in_val = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

	assign s_tready = (state_q == ST_IDLE);
	assign req      = s_tvalid && s_tready;
	assign smp_wr   = req && (in_cmd == CMD_SAMPLE);
	assign coef_wr  = req && (in_cmd == CMD_COEF) && (32'(in_idx) < MAX_TAPS);

	assign wptr_nxt = (wptr_q == AW'(MAX_TAPS - 1)) ? '0 : wptr_q + 1'b1;

	always_comb begin
		priority if (factor == '0) begin
			fac_eff = FACTOR_W'(1);
		end else if (32'(factor) > MAX_FACTOR) begin
			fac_eff = FACTOR_W'(MAX_FACTOR);
		end else begin
			fac_eff = factor;
		end
	end

	assign phase_lim = PHASE_W'(fac_eff - 1'b1);
	assign due       = smp_wr && (phase_q >= phase_lim);
	assign taps_eff  = (32'(taps) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(taps);

	always_comb begin
		issue      = '0;
		issue.vld  = (state_q == ST_RUN);
		issue.clr  = (k_q == '0);
		issue.last = (k_q == n_q - 1'b1);
		issue.nul  = nul_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wptr_q  <= '0;
			rptr_q  <= '0;
			phase_q <= '0;
			k_q     <= '0;
			n_q     <= '0;
			nul_q   <= 1'b0;
			dv_q    <= '0;
			cv_q    <= '0;
			ctl_s2  <= '0;
			dv_s2   <= 1'b0;
			cv_s2   <= 1'b0;
		end else begin
			ctl_s2 <= issue;
			dv_s2  <= dv_q[rptr_q];
			cv_s2  <= cv_q[k_q[AW-1:0]];
			if (coef_wr) begin
				cv_q[AW'(in_idx)] <= 1'b1;
			end
			if (smp_wr) begin
				wptr_q         <= wptr_nxt;
				dv_q[wptr_nxt] <= 1'b1;
				phase_q        <= due ? '0 : phase_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (due) begin
						state_q <= ST_RUN;
						rptr_q  <= wptr_nxt;
						k_q     <= '0;
						n_q     <= (taps_eff == '0) ? CNT_W'(1) : taps_eff;
						nul_q   <= (taps_eff == '0);
					end
				end
				ST_RUN: begin
					// walk back from the newest sample, one tap per cycle
					rptr_q <= (rptr_q == '0) ? AW'(MAX_TAPS - 1) : rptr_q - 1'b1;
					k_q    <= k_q + 1'b1;
					if (issue.last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	fird_ram #(
		.DEPTH (MAX_TAPS),
		.WIDTH (SAMPLE_WIDTH)
	) u_dly_ram (
		.clk   (clk),
		.we    (smp_wr),
		.waddr (wptr_nxt),
		.wdata (in_val[SAMPLE_WIDTH-1:0]),
		.raddr (rptr_q),
		.rdata (smp_rd)
	);

	fird_ram #(
		.DEPTH (MAX_TAPS),
		.WIDTH (COEF_WIDTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_wr),
		.waddr (AW'(in_idx)),
		.wdata (in_val[COEF_WIDTH-1:0]),
		.raddr (k_q[AW-1:0]),
		.rdata (coef_rd)
	);

	// never-written entries read as zero
	always_comb begin
		mac_ctl     = ctl_s2;
		mac_ctl.nul = ctl_s2.nul || !dv_s2 || !cv_s2;
	end

	fird_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.smp    ($signed(smp_rd)),
		.coef   ($signed(coef_rd)),
		.done   (mac_done),
		.result (mac_result)
	);

	assign load_out = (state_q == ST_FLUSH) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= mac_result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_WAIT))
		else $error("MAC finished outside the wait state");

	a_beat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q < n_q))
		else $error("tap counter ran past the taps in use");

	a_due_starts: assert property (@(posedge clk) disable iff (!arst_n)
		due |=> (state_q == ST_RUN))
		else $error("output-completing sample did not start a pass");

	a_flush_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (m_tvalid && (state_q == ST_IDLE)))
		else $error("result not presented after flush");

endmodule

`default_nettype wire
